@@ design/rrcs_pkg.sv @@
// Shared types and constants for the round-robin context switch table.
`default_nettype none
package rrcs_pkg;

    // Fixed field widths.
    localparam int PTR_W         = 64;
    localparam int TID_W         = 4;
    localparam int DEPTH_W       = 8;
    localparam int MAX_THREADS_D = 16;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'd255;

    // Operation codes carried in the operation field.
    typedef enum logic [1:0] {
        OP_SWITCH  = 2'd0,
        OP_CREATE  = 2'd1,
        OP_DISABLE = 2'd2,
        OP_ENABLE  = 2'd3
    } op_t;

    // Input beat.
    typedef struct packed {
        logic [1:0]       operation;
        logic [PTR_W-1:0] stack_pointer;
    } in_beat_t;

    // Result beat.
    typedef struct packed {
        logic [PTR_W-1:0] resume_pointer;
        logic             switched;
        logic             accepted;
        logic [TID_W-1:0] current_thread;
    } out_beat_t;

    // Status of one item, passed from the scheduler to the result stage.
    typedef struct packed {
        logic             switched;
        logic             accepted;
        logic [TID_W-1:0] current_thread;
    } sched_res_t;

endpackage
`default_nettype wire

@@ design/rrcs_mem.sv @@
// Saved stack pointer memory: one write port, one registered read port.
`default_nettype none
module rrcs_mem #(
    parameter int DEPTH = rrcs_pkg::MAX_THREADS_D
) (
    input  wire logic                           aclk,
    input  wire logic                           wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]       wr_addr,
    input  wire logic [rrcs_pkg::PTR_W-1:0]     wr_data,
    input  wire logic                           rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]       rd_addr,
    output logic      [rrcs_pkg::PTR_W-1:0]     rd_data
);
    import rrcs_pkg::*;

    logic [PTR_W-1:0] ram_reg [DEPTH];
    logic [PTR_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ design/rrcs_sched.sv @@
// Scheduler state: thread count, current index, preemption nesting and memory requests.
`default_nettype none
module rrcs_sched #(
    parameter int MAX_THREADS = rrcs_pkg::MAX_THREADS_D
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             item_en,
    input  wire rrcs_pkg::in_beat_t               item,
    output logic                                  wr_en,
    output logic [$clog2(MAX_THREADS)-1:0]        wr_addr,
    output logic [rrcs_pkg::PTR_W-1:0]            wr_data,
    output logic                                  rd_en,
    output logic [$clog2(MAX_THREADS)-1:0]        rd_addr,
    output rrcs_pkg::sched_res_t                  res
);
    import rrcs_pkg::*;

    localparam int IDX_W = $clog2(MAX_THREADS);
    localparam int CNT_W = $clog2(MAX_THREADS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_THREADS);

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   index_reg, index_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;

    op_t              op;
    logic [CNT_W-1:0] succ;
    logic [IDX_W-1:0] rr_next;
    logic             preempt_on;

    assign op         = op_t'(item.operation);
    assign preempt_on = (depth_reg == '0);

    // Round-robin successor of the current thread, wrapping at the count.
    always_comb begin
        succ    = CNT_W'(index_reg) + CNT_W'(1);
        rr_next = (succ >= count_reg) ? '0 : succ[IDX_W-1:0];
    end

    // Next state, memory requests and item status.
    always_comb begin
        count_next         = count_reg;
        index_next         = index_reg;
        depth_next         = depth_reg;
        wr_en              = 1'b0;
        wr_addr            = index_reg;
        wr_data            = item.stack_pointer;
        rd_en              = 1'b0;
        rd_addr            = rr_next;
        res.switched       = 1'b0;
        res.accepted       = 1'b1;
        case (op)
            OP_SWITCH: begin
                if (preempt_on) begin
                    wr_en        = item_en;
                    index_next   = rr_next;
                    res.switched = (rr_next != index_reg);
                    rd_en        = item_en && res.switched;
                end
            end
            OP_CREATE: begin
                wr_addr = count_reg[IDX_W-1:0];
                if (count_reg < CNT_MAX) begin
                    wr_en      = item_en;
                    count_next = count_reg + CNT_W'(1);
                end else begin
                    res.accepted = 1'b0;
                end
            end
            OP_DISABLE: begin
                if (depth_reg != DEPTH_MAX) begin
                    depth_next = depth_reg + DEPTH_W'(1);
                end
            end
            OP_ENABLE: begin
                if (depth_reg != '0) begin
                    depth_next = depth_reg - DEPTH_W'(1);
                end
            end
            default: begin
                res.accepted = 1'b1;
            end
        endcase
        res.current_thread = TID_W'(index_next);
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CNT_W'(1);
            index_reg <= '0;
            depth_reg <= '0;
        end else if (item_en) begin
            count_reg <= count_next;
            index_reg <= index_next;
            depth_reg <= depth_next;
        end
    end

    // The thread count always stays within one and the table depth.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) && (count_reg <= CNT_MAX))
        else $error("thread count out of range");

    // The current thread is always one that exists.
    a_index_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'(index_reg) < count_reg)
        else $error("current thread beyond thread count");

    // A read never targets the entry written in the same cycle.
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write hit the same entry");

    // A switch that moves on reads the new thread's pointer and lands on it.
    a_switch_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |=> (index_reg == $past(rd_addr)))
        else $error("switch did not land on the thread it read");

endmodule
`default_nettype wire

@@ design/round_robin_context_switch_table.sv @@
// Top level of the round-robin context switch table.
// Each accepted item is applied to the thread state and its status is held in the
// pending result register while the pointer memory's registered read port returns
// the resuming thread's stack pointer; the result then moves into the output
// register. The next item is accepted as soon as the result has left the pending
// register, even while it still waits on m_ready, so the block does not take a new
// item before the previous result has moved into the output register. The pointer
// memory has no reset and needs no clearing pass; the block accepts items as soon
// as reset is released.
`default_nettype none
module round_robin_context_switch_table #(
    parameter int MAX_THREADS = rrcs_pkg::MAX_THREADS_D
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire rrcs_pkg::in_beat_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output rrcs_pkg::out_beat_t      m_data
);
    import rrcs_pkg::*;

    localparam int IDX_W = $clog2(MAX_THREADS);

    logic             accept;
    logic             wr_en, rd_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [PTR_W-1:0] wr_data, rd_data;
    sched_res_t       res;

    logic       pend_reg, pend_next;
    sched_res_t res_reg;
    logic       out_valid_reg, out_valid_next;
    out_beat_t  out_reg;
    logic       load;

    assign s_ready = !pend_reg;
    assign accept  = s_valid && s_ready;

    rrcs_sched #(
        .MAX_THREADS (MAX_THREADS)
    ) u_sched (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item_en (accept),
        .item    (s_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .res     (res)
    );

    rrcs_mem #(
        .DEPTH (MAX_THREADS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Result moves to the output register once that register is free.
    always_comb begin
        load           = pend_reg && (!out_valid_reg || m_ready);
        pend_next      = accept || (pend_reg && !load);
        out_valid_next = load || (out_valid_reg && !m_ready);
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res;
        end
        if (load) begin
            out_reg.resume_pointer <= res_reg.switched ? rd_data : '0;
            out_reg.switched       <= res_reg.switched;
            out_reg.accepted       <= res_reg.accepted;
            out_reg.current_thread <= res_reg.current_thread;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

@@ test/round_robin_context_switch_table_tb.sv @@
// Testbench for the round-robin context switch table: directed rows, random traffic, checks.
module round_robin_context_switch_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rrcs_pkg::*;

    localparam int RAND_ITEMS = 1580;
    localparam int CALM_TAIL  = 150;
    localparam int SAT_AT     = 600;
    localparam int SAT_LEN    = 260;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN      = 10;
    localparam int LIMIT      = 200000;

    localparam logic [PTR_W-1:0] PTR_ONES = '1;
    localparam logic [PTR_W-1:0] PTR_FIVES = 64'h5555_5555_5555_5555;
    localparam logic [PTR_W-1:0] PTR_TENS = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [PTR_W-1:0] PTR_MIX = 64'h0123_4567_89AB_CDEF;

    // Result of any item that leaves thread 0 running without a switch.
    localparam out_beat_t STAY_RES = {64'd0, 1'b0, 1'b1, 4'd0};

    typedef struct {
        in_beat_t  beat;
        bit        typed;
        out_beat_t res;
    } dir_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    // Shadow copy of the scheduler state.
    logic [PTR_W-1:0]   ptr_table [MAX_THREADS_D];
    logic [4:0]         n_threads;
    logic [TID_W-1:0]   cur_tid;
    logic [DEPTH_W-1:0] nest_depth;

    out_beat_t due_results [$];
    dir_row_t  dir_rows [$];
    int        mismatches   = 0;
    int        results_seen = 0;
    bit        calm         = 1'b0;
    int        hold_left    = 0;
    int        gap_left     = 0;

    round_robin_context_switch_table dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Apply one item to the shadow state and return the result it should produce.
    task automatic predict_schedule(input in_beat_t b, output out_beat_t r);
        logic [TID_W-1:0] prev;
        logic [4:0]       nxt;
        r = '0;
        r.accepted = 1'b1;
        case (op_t'(b.operation))
            OP_SWITCH: begin
                // Switches are frozen while preemption is disabled.
                if (nest_depth == '0) begin
                    prev = cur_tid;
                    nxt = {1'b0, prev} + 5'd1;
                    ptr_table[prev] = b.stack_pointer;
                    if (nxt >= n_threads)
                        nxt = '0;
                    cur_tid = nxt[TID_W-1:0];
                    if (cur_tid != prev) begin
                        r.resume_pointer = ptr_table[cur_tid];
                        r.switched = 1'b1;
                    end
                end
            end
            OP_CREATE: begin
                if (n_threads < MAX_THREADS_D) begin
                    ptr_table[n_threads[TID_W-1:0]] = b.stack_pointer;
                    n_threads = n_threads + 5'd1;
                end else begin
                    r.accepted = 1'b0;
                end
            end
            OP_DISABLE: begin
                if (nest_depth != DEPTH_MAX)
                    nest_depth = nest_depth + 8'd1;
            end
            OP_ENABLE: begin
                if (nest_depth != '0)
                    nest_depth = nest_depth - 8'd1;
            end
            default: begin
                r.accepted = 1'b1;
            end
        endcase
        r.current_thread = cur_tid;
    endtask

    // Offer one beat, wait for it to be taken, then queue its expected result.
    task automatic offer(input in_beat_t b, input bit typed, input out_beat_t typed_res);
        out_beat_t r;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_schedule(b, r);
        due_results.push_back(typed ? typed_res : r);
    endtask

    function automatic dir_row_t mk_row(op_t op, logic [PTR_W-1:0] sp, bit typed,
                                        out_beat_t res);
        dir_row_t row;
        row.beat.operation     = op;
        row.beat.stack_pointer = sp;
        row.typed              = typed;
        row.res                = res;
        return row;
    endfunction

    // Result side: check each beat and shape m_ready with gaps and one long hold.
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, got %h", $time, m_data);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                if (m_data.resume_pointer !== want.resume_pointer) begin
                    $display("%0t: resume_pointer expected %h, got %h",
                             $time, want.resume_pointer, m_data.resume_pointer);
                    mismatches++;
                end
                if (m_data.switched !== want.switched) begin
                    $display("%0t: switched expected %b, got %b",
                             $time, want.switched, m_data.switched);
                    mismatches++;
                end
                if (m_data.accepted !== want.accepted) begin
                    $display("%0t: accepted expected %b, got %b",
                             $time, want.accepted, m_data.accepted);
                    mismatches++;
                end
                if (m_data.current_thread !== want.current_thread) begin
                    $display("%0t: current_thread expected %0d, got %0d",
                             $time, want.current_thread, m_data.current_thread);
                    mismatches++;
                end
            end
            results_seen++;
            if (results_seen == HOLD_AT)
                hold_left = HOLD_LEN;
        end

        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            m_ready <= 1'b0;
        end else if (aresetn && !calm && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 4) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog on the whole run.
    initial begin
        repeat (LIMIT) @(posedge aclk);
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus: reset, directed rows, random traffic, then drain.
    initial begin
        int               pick;
        op_t              op;
        in_beat_t         b;
        logic [PTR_W-1:0] sp;

        foreach (ptr_table[i])
            ptr_table[i] = '0;
        n_threads  = 5'd1;
        cur_tid    = '0;
        nest_depth = '0;

        // Single thread, preemption nesting at zero, then three threads in rotation.
        dir_rows.push_back(mk_row(OP_SWITCH,  PTR_ONES, 1, STAY_RES));
        dir_rows.push_back(mk_row(OP_DISABLE, PTR_MIX,  1, STAY_RES));
        dir_rows.push_back(mk_row(OP_SWITCH,  PTR_MIX,  1, STAY_RES));
        dir_rows.push_back(mk_row(OP_ENABLE,  '0,       1, STAY_RES));
        dir_rows.push_back(mk_row(OP_ENABLE,  PTR_ONES, 1, STAY_RES));
        dir_rows.push_back(mk_row(OP_CREATE,  PTR_ONES, 1, STAY_RES));
        dir_rows.push_back(mk_row(OP_CREATE,  '0,       1, STAY_RES));
        dir_rows.push_back(mk_row(OP_SWITCH,  PTR_FIVES, 1, {PTR_ONES, 1'b1, 1'b1, 4'd1}));
        dir_rows.push_back(mk_row(OP_SWITCH,  PTR_TENS, 1, {64'd0, 1'b1, 1'b1, 4'd2}));
        dir_rows.push_back(mk_row(OP_SWITCH,  PTR_MIX,  1, {PTR_FIVES, 1'b1, 1'b1, 4'd0}));
        dir_rows.push_back(mk_row(OP_DISABLE, PTR_ONES, 1, STAY_RES));
        dir_rows.push_back(mk_row(OP_SWITCH,  PTR_ONES, 1, STAY_RES));
        dir_rows.push_back(mk_row(OP_ENABLE,  PTR_ONES, 1, STAY_RES));
        dir_rows.push_back(mk_row(OP_SWITCH,  PTR_ONES, 0, STAY_RES));
        dir_rows.push_back(mk_row(OP_CREATE,  PTR_TENS, 0, STAY_RES));
        dir_rows.push_back(mk_row(OP_CREATE,  PTR_FIVES, 0, STAY_RES));
        dir_rows.push_back(mk_row(OP_SWITCH,  '0,       0, STAY_RES));
        dir_rows.push_back(mk_row(OP_SWITCH,  PTR_MIX,  0, STAY_RES));
        dir_rows.push_back(mk_row(OP_SWITCH,  PTR_TENS, 0, STAY_RES));
        dir_rows.push_back(mk_row(OP_SWITCH,  PTR_FIVES, 0, STAY_RES));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            offer(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].res);

        // Mostly switches with the odd create, a nesting walk, and one saturation sweep.
        for (int k = 0; k < RAND_ITEMS; k++) begin
            calm = (k >= RAND_ITEMS - CALM_TAIL);
            if (k >= SAT_AT && k < SAT_AT + SAT_LEN) begin
                op = OP_DISABLE;
            end else if (k >= SAT_AT + SAT_LEN && k < SAT_AT + SAT_LEN + 3) begin
                op = OP_SWITCH;
            end else if (k >= SAT_AT + SAT_LEN + 3 && k < SAT_AT + 2 * SAT_LEN + 3) begin
                op = OP_ENABLE;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 78)
                    op = OP_SWITCH;
                else if (pick < 82)
                    op = OP_CREATE;
                else if (pick < 90)
                    op = OP_DISABLE;
                else
                    op = OP_ENABLE;
            end
            case ($urandom_range(0, 9))
                0:       sp = '0;
                1:       sp = PTR_ONES;
                default: sp = {$urandom, $urandom};
            endcase
            b.operation     = op;
            b.stack_pointer = sp;
            offer(b, 1'b0, STAY_RES);
        end
        s_valid <= 1'b0;

        while (due_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        if (mismatches == 0 && due_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
